// File: rtl/csct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csct_pkg
// shared constants, codes and types of the context symbol counter table
// ----------------------------------------------------------------------------
package csct_pkg;

	localparam int CONTEXTS    = 4096;
	localparam int MAX_SYMBOLS = 16;
	localparam int CNT_W       = 16;
	localparam int CTX_W       = $clog2(CONTEXTS);
	localparam int SYM_W       = $clog2(MAX_SYMBOLS);
	localparam int NSYM_W      = $clog2(MAX_SYMBOLS + 1);
	localparam int ROW_W       = MAX_SYMBOLS * CNT_W;

	localparam logic [CNT_W-1:0]  CNT_LIMIT   = CNT_W'(65535);
	localparam logic [NSYM_W-1:0] NSYM_RESET  = NSYM_W'(4);
	localparam logic [NSYM_W-1:0] NSYM_MAX    = NSYM_W'(MAX_SYMBOLS);
	localparam logic [CTX_W-1:0]  CTX_LAST    = CTX_W'(CONTEXTS - 1);

	// item actions
	localparam logic ACT_INC = 1'b0;
	localparam logic ACT_DEC = 1'b1;

	// classified item handed from front to back
	typedef struct packed {
		logic              action;
		logic [SYM_W-1:0]  symbol;
		logic [CTX_W-1:0]  ctx;
		logic [NSYM_W-1:0] used;
		logic              rejected;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [CNT_W-1:0] count_after;
		logic             halved;
		logic             rejected;
	} res_t;

	// back part to front part
	typedef struct packed {
		logic clearing;
		logic cmd_pop;
	} back_stat_t;

endpackage

// File: rtl/context_symbol_counter_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// context_symbol_counter_table_unit
// per-context symbol counters with increment, saturating decrement and halving
// ----------------------------------------------------------------------------
// An item addresses one 16-bit counter by context row and symbol. action 0
// increments it and, when it reaches the limit, halves every counter of the
// row that is in use; action 1 decrements it down to zero. Each item yields
// one result with the new counter value and the halving flag; a symbol at or
// above num_symbols (saturated to 16) gives a rejected result and leaves the
// table alone. Rows are 16 counters wide and kept in one 4096 x 256-bit ram,
// so a whole row, halving included, is read and written back in one pass:
// an accepted item goes through a registered ram read, then update and write,
// a rejected one gets its result without a ram read, and items are worked
// one at a time since the next may hit the same row. A two-entry command
// queue and a two-entry result queue sit at either side. After reset the
// table is cleared one row per cycle, with full held high; config writes
// are always taken (cfg_ready is tied high) and belong to idle time.
module context_symbol_counter_table_unit
	import csct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [3:0]  symbol,
	input  logic [11:0] context_index,
	// result output
	output logic        empty,
	input  logic        pop,
	output logic [15:0] count_after,
	output logic        halved,
	output logic        rejected,
	// config register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	logic [NSYM_W-1:0] num_symbols_q;
	logic              cmd_empty;
	cmd_t              cmd;
	back_stat_t        bstat;
	res_t              res;

	// config transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_symbols_q <= NSYM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_symbols_q <= NSYM_W'(cfg_data);
		end
	end

	// front end: classify and queue
	csct_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.symbol       (symbol),
		.context_index(context_index),
		.num_symbols  (num_symbols_q),
		.bstat        (bstat),
		.cmd_empty    (cmd_empty),
		.cmd          (cmd)
	);

	// back end: table clear, row update, result queue
	csct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.bstat    (bstat),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign count_after = 16'(res.count_after);
	assign halved      = res.halved;
	assign rejected    = res.rejected;

endmodule

// File: rtl/csct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csct_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module csct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/csct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csct_front
// accepts items, checks the symbol against the count in use, queues commands
// ----------------------------------------------------------------------------
module csct_front
	import csct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic [3:0]        symbol,
	input  logic [11:0]       context_index,
	input  logic [NSYM_W-1:0] num_symbols,
	input  back_stat_t        bstat,
	output logic              cmd_empty,
	output cmd_t              cmd
);

	cmd_t             cmd_mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             xfer_in;
	logic [NSYM_W-1:0] used;
	cmd_t             cmd_new;

	// symbol count saturates at the row width
	assign used = (num_symbols > NSYM_MAX) ? NSYM_MAX : num_symbols;

	always_comb begin
		cmd_new.action   = action;
		cmd_new.symbol   = SYM_W'(symbol);
		cmd_new.ctx      = CTX_W'(context_index);
		cmd_new.used     = used;
		cmd_new.rejected = ({1'b0, SYM_W'(symbol)} >= used);
	end

	assign full      = (cnt_q == 2'd2) || bstat.clearing;
	assign xfer_in   = push && !full;
	assign cmd_empty = (cnt_q == 2'd0);
	assign cmd       = cmd_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (xfer_in) begin
			cmd_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (xfer_in) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (bstat.cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({xfer_in, bstat.cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.cmd_pop |-> !cmd_empty) else $error("command pop from empty queue");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.clearing |-> (full && !xfer_in)) else $error("item taken during clear");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("command queue count overflow");

endmodule

// File: rtl/csct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csct_back
// clears the table, runs the row read-modify-write, queues results
// ----------------------------------------------------------------------------
module csct_back
	import csct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_empty,
	input  cmd_t       cmd,
	output back_stat_t bstat,
	input  logic       pop,
	output logic       empty,
	output res_t       res
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_MOD   = 2'd2;

	logic [1:0]       state_q;
	logic [CTX_W-1:0] clr_q;
	cmd_t             cmd_q;

	logic             ram_we;
	logic [CTX_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic             ram_re;
	logic [ROW_W-1:0] ram_rdata;

	res_t             res_mem_q [2];
	logic             res_wr_q;
	logic             res_rd_q;
	logic [1:0]       res_cnt_q;
	logic             res_full;
	logic             res_push;
	logic             res_pop;
	res_t             res_in;

	logic             take;
	logic [CNT_W-1:0] cur;
	logic [CNT_W-1:0] nxt;
	logic             do_halve;
	logic [ROW_W-1:0] row_new;

	csct_ram #(
		.WIDTH(ROW_W),
		.DEPTH(CONTEXTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cmd.ctx),
		.rdata(ram_rdata)
	);

	assign res_full = (res_cnt_q == 2'd2);
	assign empty    = (res_cnt_q == 2'd0);
	assign res      = res_mem_q[res_rd_q];
	assign res_pop  = pop && !empty;

	// one command at a time, only with room for its result
	assign take           = (state_q == ST_IDLE) && !cmd_empty && !res_full;
	assign ram_re         = take && !cmd.rejected;
	assign bstat.cmd_pop  = take;
	assign bstat.clearing = (state_q == ST_CLEAR);

	// counter update on the row just read
	always_comb begin
		cur = ram_rdata[cmd_q.symbol*CNT_W +: CNT_W];
		if (cmd_q.action == ACT_INC) begin
			nxt = cur + CNT_W'(1);
		end else begin
			nxt = (cur == '0) ? cur : cur - CNT_W'(1);
		end
		do_halve = (cmd_q.action == ACT_INC) && (nxt >= CNT_LIMIT);
		for (int k = 0; k < MAX_SYMBOLS; k++) begin
			row_new[k*CNT_W +: CNT_W] = ram_rdata[k*CNT_W +: CNT_W];
			if (SYM_W'(k) == cmd_q.symbol) begin
				row_new[k*CNT_W +: CNT_W] = nxt;
			end
			if (do_halve && (NSYM_W'(k) < cmd_q.used)) begin
				row_new[k*CNT_W +: CNT_W] = row_new[k*CNT_W +: CNT_W] >> 1;
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cmd_q.ctx;
		ram_wdata = row_new;
		res_push  = 1'b0;
		res_in    = '{count_after: '0, halved: 1'b0, rejected: 1'b1};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				res_push = take && cmd.rejected;
			end
			ST_MOD: begin
				ram_we   = 1'b1;
				res_push = 1'b1;
				res_in.count_after = do_halve ? (nxt >> 1) : nxt;
				res_in.halved      = do_halve;
				res_in.rejected    = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
		end
		if (res_push) begin
			res_mem_q[res_wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CTX_W'(1);
					if (clr_q == CTX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (ram_re) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (res_push) begin
				res_wr_q <= ~res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= ~res_rd_q;
			end
			case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into full queue");

	a_mod_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |=> state_q == ST_IDLE) else $error("update stalled");

	a_halve_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_in.halved) |-> (!res_in.rejected && cmd_q.action == ACT_INC))
		else $error("halving outside an increment");

endmodule

// File: verif/context_symbol_counter_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// context_symbol_counter_table_unit_tb
// self-checking bench for the per-context symbol counter table
// ----------------------------------------------------------------------------
// Items and symbol count writes are queued up front and fed to the block by
// a clocked driver, with random gaps on the push side and random stalls on
// the pop side. A local copy of the counter table predicts every result at
// the transfer in; the monitor compares each popped result field by field.
// The run covers a short directed set, one row with several counters that is
// then worked with fewer symbols in use, and random phases over several
// symbol counts, zero and out-of-range counts among them.
// ----------------------------------------------------------------------------
module context_symbol_counter_table_unit_tb;
	import csct_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int RESET_LEN   = 11;
	localparam int SETTLE      = 8;
	localparam int DRAIN_WAIT  = 20;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASE_ITEMS = 170;
	localparam int MAX_REPORTS = 10;
	localparam logic [CTX_W-1:0] HALVE_ROW = 12'h5A3;

	// one queued operation: an item or a symbol count write
	typedef struct packed {
		logic              is_cfg;
		logic              rush;
		logic              act;
		logic [SYM_W-1:0]  sym;
		logic [CTX_W-1:0]  ctx;
		logic [4:0]        cfg_val;
	} op_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        action = 1'b0;
	logic [3:0]  symbol = '0;
	logic [11:0] context_index = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] count_after;
	logic        halved;
	logic        rejected;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;

	// predictor state
	logic [CNT_W-1:0] count_table [CONTEXTS][MAX_SYMBOLS];
	logic [4:0]       nsym_model = NSYM_RESET;
	res_t             expected_counts [$];
	op_t              op_queue [$];

	logic [CTX_W-1:0] hot_ctx [8] = '{12'h000, 12'hFFF, 12'h001, 12'h800,
		12'h555, 12'hAAA, 12'h04D, 12'hBB8};

	logic run_on = 1'b0;
	logic drive_done = 1'b0;
	logic rush_mode = 1'b0;
	int   cycle_count = 0;
	int   error_count = 0;
	int   report_count = 0;
	int   items_sent = 0;
	int   results_seen = 0;
	int   rejects_seen = 0;
	int   halvings_seen = 0;
	int   cfg_writes = 0;

	context_symbol_counter_table_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.symbol        (symbol),
		.context_index (context_index),
		.empty         (empty),
		.pop           (pop),
		.count_after   (count_after),
		.halved        (halved),
		.rejected      (rejected),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// counter update of one item on the local table
	function automatic res_t predict_count(input logic act, input logic [SYM_W-1:0] sym,
		input logic [CTX_W-1:0] ctx);
		res_t        r;
		int          used;
		logic [15:0] v;
		r = '0;
		// symbol count saturates at the row width
		used = (nsym_model > NSYM_MAX) ? MAX_SYMBOLS : int'(nsym_model);
		if (int'(sym) >= used) begin
			r.rejected = 1'b1;
			return r;
		end
		v = count_table[ctx][sym];
		if (act == ACT_INC) begin
			v = v + 16'd1;
			count_table[ctx][sym] = v;
			// at the limit the symbols in use are halved, unused ones kept
			if (v >= CNT_LIMIT) begin
				for (int k = 0; k < used; k++)
					count_table[ctx][k] = count_table[ctx][k] >> 1;
				r.halved = 1'b1;
				v = count_table[ctx][sym];
			end
		end else begin
			// decrement saturates at zero
			if (v != 16'd0)
				v = v - 16'd1;
			count_table[ctx][sym] = v;
		end
		r.count_after = v;
		return r;
	endfunction

	// idle cycles before a transfer: rare in a rush, none while calm
	function automatic int draw_wait(input logic hurry, input logic calm);
		if (hurry)
			return ($urandom_range(0, 499) == 0) ? int'($urandom_range(0, 17)) : 0;
		if (calm)
			return 0;
		return int'($urandom_range(0, 17));
	endfunction

	function automatic void queue_item(input logic act, input int sym, input int ctx,
		input logic hurry);
		op_t o;
		o = '0;
		o.act = act;
		o.sym = SYM_W'(sym);
		o.ctx = CTX_W'(ctx);
		o.rush = hurry;
		op_queue.push_back(o);
	endfunction

	function automatic void queue_cfg(input int val);
		op_t o;
		o = '0;
		o.is_cfg = 1'b1;
		o.cfg_val = 5'(val);
		op_queue.push_back(o);
	endfunction

	// push side: item transfers and symbol count writes
	always @(posedge clk) begin : item_driver
		logic push_n;
		logic cfgv_n;
		int   g;
		op_t  head;
		static int   gap_left = 0;
		static int   settle_left = 0;
		static logic have_item = 1'b0;
		static logic calm_in = 1'b0;
		push_n = push;
		cfgv_n = cfg_valid;
		if (run_on) begin
			if (push && !full) begin
				expected_counts.push_back(predict_count(action, symbol, context_index));
				items_sent++;
				settle_left = SETTLE;
				push_n = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				nsym_model = cfg_data;
				cfg_writes++;
				cfgv_n = 1'b0;
			end
			if (!push_n && !cfgv_n) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (have_item) begin
					push_n = 1'b1;
					have_item = 1'b0;
				end else if (op_queue.size() > 0) begin
					if (op_queue[0].is_cfg) begin
						// writes only once the block has gone quiet
						if (expected_counts.size() != 0) begin
							settle_left = SETTLE;
						end else if (settle_left > 0) begin
							settle_left--;
						end else begin
							head = op_queue.pop_front();
							cfg_data <= head.cfg_val;
							cfgv_n = 1'b1;
						end
					end else begin
						head = op_queue.pop_front();
						action <= head.act;
						symbol <= head.sym;
						context_index <= head.ctx;
						rush_mode <= head.rush;
						if ($urandom_range(0, 39) == 0)
							calm_in = !calm_in;
						g = draw_wait(head.rush, calm_in);
						if (g == 0) begin
							push_n = 1'b1;
						end else begin
							gap_left = g - 1;
							have_item = 1'b1;
						end
					end
				end else begin
					drive_done <= 1'b1;
				end
			end
		end
		push <= push_n;
		cfg_valid <= cfgv_n;
	end

	// pop side: result transfers checked against the oldest expectation
	always @(posedge clk) begin : result_monitor
		logic pop_n;
		res_t want;
		static int   stall_left = 0;
		static logic calm_out = 1'b0;
		pop_n = pop;
		if (run_on) begin
			if (pop && !empty) begin
				results_seen++;
				if (rejected)
					rejects_seen++;
				if (halved)
					halvings_seen++;
				if (expected_counts.size() == 0) begin
					error_count++;
					if (report_count < MAX_REPORTS) begin
						report_count++;
						$display("unexpected result: count %0d halved %0b rejected %0b",
							count_after, halved, rejected);
					end
				end else begin
					want = expected_counts.pop_front();
					if (count_after !== want.count_after || halved !== want.halved ||
						rejected !== want.rejected) begin
						error_count++;
						if (report_count < MAX_REPORTS) begin
							report_count++;
							$display("result %0d mismatch: expected %0d h%0b r%0b, got %0d h%0b r%0b",
								results_seen, want.count_after, want.halved, want.rejected,
								count_after, halved, rejected);
						end
					end
				end
				if ($urandom_range(0, 39) == 0)
					calm_out = !calm_out;
				stall_left = draw_wait(rush_mode, calm_out);
				pop_n = (stall_left == 0);
			end else if (!pop) begin
				if (stall_left > 0)
					stall_left--;
				else
					pop_n = 1'b1;
			end
		end
		pop <= pop_n;
	end

	// watchdog, also covers the clearing pass after reset
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_counts.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int   used;
		int   sym;
		int   ctx;
		logic act;
		int   nsym_list [8];

		for (int c = 0; c < CONTEXTS; c++)
			for (int s = 0; s < MAX_SYMBOLS; s++)
				count_table[c][s] = '0;

		// directed: reset symbol count of four first
		queue_item(ACT_INC, 0, 0, 1'b0);
		queue_item(ACT_DEC, 0, 0, 1'b0);
		queue_item(ACT_DEC, 0, 0, 1'b0);         // decrement at zero
		queue_item(ACT_INC, 3, 4095, 1'b0);      // last context, last symbol in use
		queue_item(ACT_INC, 4, 4095, 1'b0);      // symbol at the count
		queue_item(ACT_DEC, 15, 12'hAAA, 1'b0);
		queue_cfg(16);
		queue_item(ACT_INC, 15, 4095, 1'b0);
		queue_item(ACT_INC, 15, 4095, 1'b0);
		queue_item(ACT_DEC, 15, 4095, 1'b0);
		queue_item(ACT_INC, 10, 12'h555, 1'b0);
		queue_cfg(0);                            // everything rejected
		queue_item(ACT_INC, 0, 0, 1'b0);
		queue_item(ACT_DEC, 3, 4095, 1'b0);
		queue_cfg(31);                           // saturates to the row width
		queue_item(ACT_INC, 15, 4095, 1'b0);
		queue_item(ACT_INC, 0, 0, 1'b0);
		queue_cfg(1);
		queue_item(ACT_INC, 0, 4095, 1'b0);
		queue_item(ACT_DEC, 1, 0, 1'b0);
		queue_item(ACT_DEC, 0, 4095, 1'b0);

		// seed a row, then work it with fewer symbols in use so that the
		// upper counters keep their values
		queue_cfg(16);
		repeat (3) queue_item(ACT_INC, 12, HALVE_ROW, 1'b0);
		repeat (7) queue_item(ACT_INC, 2, HALVE_ROW, 1'b0);
		queue_item(ACT_INC, 8, HALVE_ROW, 1'b0);
		queue_item(ACT_INC, 0, HALVE_ROW, 1'b0);
		repeat (2) queue_item(ACT_INC, 15, HALVE_ROW, 1'b0);
		queue_cfg(9);
		repeat (4) queue_item(ACT_INC, 5, HALVE_ROW, 1'b0);
		queue_item(ACT_DEC, 5, HALVE_ROW, 1'b0);
		queue_item(ACT_INC, 2, HALVE_ROW, 1'b0);
		queue_item(ACT_DEC, 8, HALVE_ROW, 1'b0);
		queue_item(ACT_INC, 0, HALVE_ROW, 1'b0);
		queue_item(ACT_DEC, 5, HALVE_ROW, 1'b0);
		queue_item(ACT_INC, 15, HALVE_ROW, 1'b0);
		queue_cfg(16);
		queue_item(ACT_INC, 12, HALVE_ROW, 1'b0);
		queue_item(ACT_DEC, 15, HALVE_ROW, 1'b0);

		// random phases over a spread of symbol counts
		nsym_list = '{16, 1, 0, 31, 17, int'($urandom_range(2, 15)), 4, 16};
		for (int p = 0; p < 8; p++) begin
			queue_cfg(nsym_list[p]);
			used = (nsym_list[p] > MAX_SYMBOLS) ? MAX_SYMBOLS : nsym_list[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// mostly a few hot rows so counters build up and decrements bite
				if ($urandom_range(0, 9) < 7)
					ctx = int'(hot_ctx[$urandom_range(0, 7)]);
				else
					ctx = int'($urandom_range(0, 4095));
				if (used > 0 && $urandom_range(0, 9) < 8)
					sym = int'($urandom_range(0, used - 1));
				else
					sym = int'($urandom_range(0, 15));
				act = ($urandom_range(0, 99) < 60) ? ACT_INC : ACT_DEC;
				queue_item(act, sym, ctx, 1'b0);
			end
		end

		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		run_on <= 1'b1;

		while (!(drive_done && expected_counts.size() == 0))
			@(posedge clk);
		// any stray result after the drain is caught by the monitor
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d items sent, %0d results checked: %0d rejected, %0d row halvings",
			items_sent, results_seen, rejects_seen, halvings_seen);
		$display("%0d symbol count writes, %0d failures", cfg_writes, error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
